/* hdl/uttc_pkg.sv */
// ----------------------------------------------------------------------------
// uttc_pkg
// Shared types and constants of the Unix time / calendar converter.
// ----------------------------------------------------------------------------
package uttc_pkg;

    localparam logic [31:0] SecPerDay  = 32'd86400;
    // reciprocals for exact 32-bit division: q = (n * Div60Recip) >> 37,
    // q = (n * Div24Recip) >> 36
    localparam logic [31:0] Div60Recip = 32'h8888_8889;
    localparam logic [31:0] Div24Recip = 32'hAAAA_AAAB;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_STEP,
        OP_DIV_CAP,
        OP_YEAR,
        OP_MONTH,
        OP_DAYS,
        OP_MUL,
        OP_SUM,
        OP_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        DIV_SEC,
        DIV_MIN,
        DIV_HOUR
    } t_div_sel;

    typedef struct packed {
        t_dp_op   op;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic dir;
        logic year_done;
        logic month_done;
    } t_sts;

endpackage

/* hdl/unix_time_calendar_converter_core.sv */
// ----------------------------------------------------------------------------
// unix_time_calendar_converter_core: Unix seconds <-> Gregorian calendar
// Seconds to calendar: the divider splits off seconds, minutes and hours, then years and
// months are walked; calendar to seconds: years and 0 to 12 months are walked, then summed.
// One request at a time; the year walk runs one year per cycle. The next request is
// taken in the cycle after the result loads. Synchronous reset drops any result.
// ----------------------------------------------------------------------------
module unix_time_calendar_converter_core import uttc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_seconds_in,
    input  logic [7:0]  i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_seconds_out,
    output logic [7:0]  o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic [31:0] o_fat_time,
    output logic        o_fat_valid
);

    // The sequencer steps the datapath through its phases:
    //   divide   - split seconds by 60, 60 and 24 by reciprocal multiplication,
    //              a product step and a capture step each; calendar requests skip this phase
    //   year     - walk years from 1970 (add 365/366 per step)
    //   month    - walk months of the found year
    //   days/mul/sum - calendar direction only: days * 86400 plus time of day
    //   out      - load the output register once the previous result has gone;
    //              hold here while an untaken result blocks it
    // A new request is taken as soon as the sequencer is idle, even while the
    // output register still holds an untaken result.

    t_cmd cmd;
    t_sts sts;

    uttc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    uttc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_seconds_in  (i_seconds_in),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_hour_in     (i_hour_in),
        .i_minute_in   (i_minute_in),
        .i_second_in   (i_second_in),
        .o_seconds_out (o_seconds_out),
        .o_year_out    (o_year_out),
        .o_month_out   (o_month_out),
        .o_day_out     (o_day_out),
        .o_hour_out    (o_hour_out),
        .o_minute_out  (o_minute_out),
        .o_second_out  (o_second_out),
        .o_fat_time    (o_fat_time),
        .o_fat_valid   (o_fat_valid)
    );

endmodule

/* hdl/uttc_dpath.sv */
// ----------------------------------------------------------------------------
// uttc_dpath
// Working registers, shared constant divider, year and month walkers,
// seconds summation and the output register.
// ----------------------------------------------------------------------------
module uttc_dpath import uttc_pkg::*; (
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_req_type,
    input  logic [31:0] i_seconds_in,
    input  logic [7:0]  i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    output logic [31:0] o_seconds_out,
    output logic [7:0]  o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic [31:0] o_fat_time,
    output logic        o_fat_valid
);

    // leap test for year 1970 + off; the only century years reached are
    // 2000 (leap), 2100 and 2200 (not leap)
    function automatic logic is_leap(input logic [7:0] off);
        logic [1:0] m4;
        m4 = off[1:0] + 2'd2;
        return (m4 == 2'd0) && (off != 8'd130) && (off != 8'd230);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    logic        r_dir;
    logic [31:0] r_secs;
    logic [7:0]  r_yr_tgt;
    logic [3:0]  r_mo;
    logic [4:0]  r_dy;
    logic [4:0]  r_hr;
    logic [5:0]  r_mi;
    logic [5:0]  r_se;
    logic [31:0] r_quo;
    logic [63:0] r_dprod;
    logic [7:0]  r_yr;
    logic [16:0] r_acc;
    logic [8:0]  r_doy;
    logic [3:0]  r_m;
    logic [31:0] r_days;
    logic [16:0] r_tod;
    logic [31:0] r_prod;

    logic [5:0]  divisor;
    logic [31:0] recip;
    logic [31:0] div_q;
    logic [5:0]  div_rem;
    logic        leap;
    logic [8:0]  year_len;
    logic [16:0] year_sum;
    logic        year_done;
    logic [4:0]  mlen;
    logic [3:0]  mlim;
    logic        month_done;
    logic [6:0]  fat_year;

    // divide by reciprocal multiplication: the product is registered in r_dprod, then
    // quotient and remainder are taken from it; the remainder is below 64 so six bits suffice
    always_comb begin
        case (i_cmd.div_sel)
            DIV_HOUR: begin
                divisor = 6'd24;
                recip   = Div24Recip;
                div_q   = {4'b0, r_dprod[63:36]};
            end
            default: begin
                divisor = 6'd60;
                recip   = Div60Recip;
                div_q   = {5'b0, r_dprod[63:37]};
            end
        endcase
    end

    assign div_rem = r_quo[5:0] - div_q[5:0] * divisor;

    assign leap     = is_leap(r_yr);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign year_sum = r_acc + {8'b0, year_len};
    // day count after the three divisions stays below 2^16
    assign year_done = r_dir ? (r_yr == r_yr_tgt) : (year_sum > {1'b0, r_quo[15:0]});

    assign mlen = month_len(r_m, leap);
    always_comb begin
        if (r_mo == 4'd0) begin
            mlim = 4'd0;
        end else if ((r_mo - 4'd1) > 4'd12) begin
            mlim = 4'd12;
        end else begin
            mlim = r_mo - 4'd1;
        end
    end
    assign month_done = r_dir ? (r_m == mlim)
                              : ((r_m == 4'd12) || (r_doy < {4'b0, mlen}));

    assign o_sts = '{dir: r_dir, year_done: year_done, month_done: month_done};

    assign fat_year = 7'(r_yr - 8'd10);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_dir    <= i_req_type;
                r_secs   <= i_seconds_in;
                r_yr_tgt <= i_year_in;
                r_mo     <= i_month_in;
                r_dy     <= i_day_in;
                r_hr     <= i_hour_in;
                r_mi     <= i_minute_in;
                r_se     <= i_second_in;
                r_quo    <= i_seconds_in;
                r_yr     <= 8'd0;
                r_acc    <= 17'd0;
                r_m      <= 4'd0;
            end
            OP_DIV_STEP: begin
                r_dprod <= {32'b0, r_quo} * {32'b0, recip};
            end
            OP_DIV_CAP: begin
                case (i_cmd.div_sel)
                    DIV_SEC:  r_se <= div_rem;
                    DIV_MIN:  r_mi <= div_rem;
                    default:  r_hr <= div_rem[4:0];
                endcase
                r_quo <= div_q;
            end
            OP_YEAR: begin
                if (!year_done) begin
                    r_acc <= year_sum;
                    r_yr  <= r_yr + 8'd1;
                end else if (!r_dir) begin
                    r_doy <= r_quo[8:0] - r_acc[8:0];
                end
            end
            OP_MONTH: begin
                if (!month_done) begin
                    r_m <= r_m + 4'd1;
                    if (r_dir) begin
                        r_acc <= r_acc + {12'b0, mlen};
                    end else begin
                        r_doy <= r_doy - {4'b0, mlen};
                    end
                end else if (!r_dir) begin
                    r_mo <= r_m + 4'd1;
                    r_dy <= r_doy[4:0] + 5'd1;
                end
            end
            OP_DAYS: begin
                r_days <= {15'b0, r_acc} + {27'b0, r_dy} - 32'd1;
                r_tod  <= {12'b0, r_hr} * 17'd3600 + {11'b0, r_mi} * 17'd60
                          + {11'b0, r_se};
            end
            OP_MUL: begin
                r_prod <= r_days * SecPerDay;
            end
            OP_SUM: begin
                r_secs <= r_prod + {15'b0, r_tod};
            end
            OP_OUT: begin
                o_seconds_out <= r_secs;
                o_year_out    <= r_yr;
                o_month_out   <= r_mo;
                o_day_out     <= r_dy;
                o_hour_out    <= r_hr;
                o_minute_out  <= r_mi;
                o_second_out  <= r_se;
                o_fat_time    <= {fat_year, r_mo, r_dy, r_hr, r_mi, r_se[5:1]};
                o_fat_valid   <= (r_yr >= 8'd10) && (r_yr <= 8'd137);
            end
            default: begin
            end
        endcase
    end

endmodule

/* hdl/uttc_ctrl.sv */
// ----------------------------------------------------------------------------
// uttc_ctrl
// Sequencer: issues datapath commands and runs both handshakes.
// ----------------------------------------------------------------------------
module uttc_ctrl import uttc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CAP,
        S_YEAR,
        S_MONTH,
        S_DAYS,
        S_MUL,
        S_SUM,
        S_OUT
    } t_state;

    t_state   r_state, n_state;
    t_div_sel r_sel, n_sel;
    logic     r_out_valid, n_out_valid;
    logic     out_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '{op: OP_NONE, div_sel: r_sel};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_sel    = DIV_SEC;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                // calendar-to-seconds requests skip the divider and start at
                // the year walk
                if (i_sts.dir) begin
                    n_state = S_YEAR;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                    n_state  = S_CAP;
                end
            end
            S_CAP: begin
                o_cmd.op = OP_DIV_CAP;
                case (r_sel)
                    DIV_SEC: begin
                        n_sel   = DIV_MIN;
                        n_state = S_DIV;
                    end
                    DIV_MIN: begin
                        n_sel   = DIV_HOUR;
                        n_state = S_DIV;
                    end
                    default: n_state = S_YEAR;
                endcase
            end
            S_YEAR: begin
                o_cmd.op = OP_YEAR;
                if (i_sts.year_done) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                o_cmd.op = OP_MONTH;
                if (i_sts.month_done) begin
                    n_state = i_sts.dir ? S_DAYS : S_OUT;
                end
            end
            S_DAYS: begin
                o_cmd.op = OP_DAYS;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= DIV_SEC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hdl/uttc_checker.sv */
// ----------------------------------------------------------------------------
// uttc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module uttc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_req_type,
    input logic [31:0] i_seconds_in,
    input logic [7:0]  i_year_in,
    input logic [3:0]  i_month_in,
    input logic [4:0]  i_day_in,
    input logic [4:0]  i_hour_in,
    input logic [5:0]  i_minute_in,
    input logic [5:0]  i_second_in,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_seconds_out,
    input logic [7:0]  o_year_out,
    input logic [3:0]  o_month_out,
    input logic [4:0]  o_day_out,
    input logic [4:0]  o_hour_out,
    input logic [5:0]  o_minute_out,
    input logic [5:0]  o_second_out,
    input logic [31:0] o_fat_time,
    input logic        o_fat_valid
);

    // drop any result on reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_seconds_out)
                                           && $stable(o_fat_time)))
        else $error("stalled result changed");

    a_fat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fat_valid == ((o_year_out >= 8'd10) && (o_year_out <= 8'd137))))
        else $error("FAT flag does not match year");

    a_fat_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_fat_time[24:21] == o_month_out)
                         && (o_fat_time[20:16] == o_day_out)
                         && (o_fat_time[15:11] == o_hour_out)
                         && (o_fat_time[10:5] == o_minute_out)
                         && (o_fat_time[4:0] == o_second_out[5:1])
                         && (o_fat_time[31:25] == 7'(o_year_out - 8'd10))))
        else $error("FAT packing does not match calendar fields");

    // a request is taken only while the sequencer is idle, so the next
    // cycle never shows ready again before work has been done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while busy");

endmodule

bind unix_time_calendar_converter_core uttc_checker u_uttc_checker (.*);

/* tb/sv/uttc_checker.sv */
// ----------------------------------------------------------------------------
// uttc_scoreboard
// Watches both channels of the converter, predicts each result from the
// accepted request and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module uttc_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_seconds_in,
    input  logic [7:0]  i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_seconds_out,
    input  logic [7:0]  i_year_out,
    input  logic [3:0]  i_month_out,
    input  logic [4:0]  i_day_out,
    input  logic [4:0]  i_hour_out,
    input  logic [5:0]  i_minute_out,
    input  logic [5:0]  i_second_out,
    input  logic [31:0] i_fat_time,
    input  logic        i_fat_valid,
    // status towards the testbench top
    output int          o_errors,
    output int          o_outstanding,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DAY_SECS   = 86400;
    localparam logic        DIR_TO_CAL = 1'b0;

    typedef struct packed {
        logic [31:0] seconds;
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] fat;
        logic        fat_ok;
    } cal_result_t;

    cal_result_t expected_cal_q[$];
    int          err_cnt = 0;
    int          res_cnt = 0;

    function automatic bit is_leap_offset(input int unsigned off);
        int unsigned y;
        y = 1970 + off;
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m,
                                                  input int unsigned off);
        if (m == 1) begin
            return is_leap_offset(off) ? 29 : 28;
        end
        case (m % 12)
            3, 5, 8, 10: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic cal_result_t convert_time(
        input logic        dir,
        input logic [31:0] secs_in,
        input logic [7:0]  yr_in,
        input logic [3:0]  mo_in,
        input logic [4:0]  dy_in,
        input logic [4:0]  hr_in,
        input logic [5:0]  mi_in,
        input logic [5:0]  se_in
    );
        cal_result_t r;
        int unsigned t, acc, len, m, mlim;
        int unsigned secs, yr, mo, dy, hr, mi, se;
        if (dir == DIR_TO_CAL) begin
            t    = secs_in;
            secs = t;
            se   = t % 60; t = t / 60;
            mi   = t % 60; t = t / 60;
            hr   = t % 24; t = t / 24;
            // walk whole years, then whole months of the year found
            yr   = 0;
            acc  = 0;
            while (1) begin
                len = is_leap_offset(yr) ? 366 : 365;
                if (acc + len > t) break;
                acc = acc + len;
                yr  = yr + 1;
            end
            t = t - acc;
            m = 0;
            while (m < 12 && t >= days_in_month(m, yr)) begin
                t = t - days_in_month(m, yr);
                m = m + 1;
            end
            mo = m + 1;
            dy = t + 1;
        end else begin
            yr   = 32'(yr_in);
            mo   = 32'(mo_in);
            dy   = 32'(dy_in);
            hr   = 32'(hr_in);
            mi   = 32'(mi_in);
            se   = 32'(se_in);
            secs = yr * 365 * DAY_SECS;
            for (int unsigned i = 0; i < yr; i++) begin
                if (is_leap_offset(i)) secs = secs + DAY_SECS;
            end
            // month 0 adds nothing, anything above 12 adds the full year
            mlim = (mo == 0) ? 0 : mo - 1;
            if (mlim > 12) mlim = 12;
            for (int unsigned i = 0; i < mlim; i++) begin
                secs = secs + days_in_month(i, yr) * DAY_SECS;
            end
            secs = secs + (dy - 1) * DAY_SECS;
            secs = secs + hr * 3600 + mi * 60 + se;
        end
        r.seconds = secs;
        r.year    = yr[7:0];
        r.month   = mo[3:0];
        r.day     = dy[4:0];
        r.hour    = hr[4:0];
        r.minute  = mi[5:0];
        r.second  = se[5:0];
        r.fat     = (((yr - 10) & 32'h7F) << 25) | ((mo & 32'hF) << 21)
                  | ((dy & 32'h1F) << 16) | ((hr & 32'h1F) << 11)
                  | ((mi & 32'h3F) << 5) | ((se & 32'h3F) >> 1);
        r.fat_ok  = (yr >= 10) && (yr <= 137);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            err_cnt++;
            $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        cal_result_t want;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                res_cnt++;
                if (expected_cal_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t ns: result with no request outstanding, seconds 0x%08h",
                             $time, i_seconds_out);
                end else begin
                    want = expected_cal_q.pop_front();
                    check_field("seconds_out", want.seconds, i_seconds_out);
                    check_field("year_out",    want.year,    i_year_out);
                    check_field("month_out",   want.month,   i_month_out);
                    check_field("day_out",     want.day,     i_day_out);
                    check_field("hour_out",    want.hour,    i_hour_out);
                    check_field("minute_out",  want.minute,  i_minute_out);
                    check_field("second_out",  want.second,  i_second_out);
                    check_field("fat_time",    want.fat,     i_fat_time);
                    check_field("fat_valid",   want.fat_ok,  i_fat_valid);
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_cal_q.push_back(convert_time(i_req_type, i_seconds_in,
                    i_year_in, i_month_in, i_day_in, i_hour_in, i_minute_in,
                    i_second_in));
            end
        end
        o_errors      <= err_cnt;
        o_outstanding <= expected_cal_q.size();
        o_results     <= res_cnt;
    end

endmodule

/* tb/sv/tb_unix_time_calendar_converter_core.sv */
// ----------------------------------------------------------------------------
// tb_unix_time_calendar_converter_core
// Drives directed and random conversion requests in both directions into the
// converter, with random idling on both channels, and reports the verdict
// from the checker's error and outstanding counts.
// ----------------------------------------------------------------------------
module tb_unix_time_calendar_converter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic DIR_TO_CAL  = 1'b0;
    localparam logic DIR_TO_SECS = 1'b1;
    localparam int   N_RANDOM    = 700;
    localparam int   IDLE_PCT    = 18;
    localparam int   DRAIN_WAIT  = 400;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_req_type   = 1'b0;
    logic [31:0] i_seconds_in = '0;
    logic [7:0]  i_year_in    = '0;
    logic [3:0]  i_month_in   = 4'd1;
    logic [4:0]  i_day_in     = 5'd1;
    logic [4:0]  i_hour_in    = '0;
    logic [5:0]  i_minute_in  = '0;
    logic [5:0]  i_second_in  = '0;
    logic        i_out_ready  = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_seconds_out;
    logic [7:0]  o_year_out;
    logic [3:0]  o_month_out;
    logic [4:0]  o_day_out;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [5:0]  o_second_out;
    logic [31:0] o_fat_time;
    logic        o_fat_valid;

    int errors;
    int outstanding;
    int results;

    // idling on both sides is switched off for one long stretch
    logic idle_on = 1'b1;
    int   n_to_cal = 0;
    int   n_to_secs = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    unix_time_calendar_converter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_seconds_in  (i_seconds_in),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_hour_in     (i_hour_in),
        .i_minute_in   (i_minute_in),
        .i_second_in   (i_second_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_seconds_out (o_seconds_out),
        .o_year_out    (o_year_out),
        .o_month_out   (o_month_out),
        .o_day_out     (o_day_out),
        .o_hour_out    (o_hour_out),
        .o_minute_out  (o_minute_out),
        .o_second_out  (o_second_out),
        .o_fat_time    (o_fat_time),
        .o_fat_valid   (o_fat_valid)
    );

    uttc_scoreboard u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_in_valid),
        .i_req_ready   (o_in_ready),
        .i_req_type    (i_req_type),
        .i_seconds_in  (i_seconds_in),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_hour_in     (i_hour_in),
        .i_minute_in   (i_minute_in),
        .i_second_in   (i_second_in),
        .i_res_valid   (o_out_valid),
        .i_res_ready   (i_out_ready),
        .i_seconds_out (o_seconds_out),
        .i_year_out    (o_year_out),
        .i_month_out   (o_month_out),
        .i_day_out     (o_day_out),
        .i_hour_out    (o_hour_out),
        .i_minute_out  (o_minute_out),
        .i_second_out  (o_second_out),
        .i_fat_time    (o_fat_time),
        .i_fat_valid   (o_fat_valid),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_results     (results)
    );

    // Stall the result side at random, except during the quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!idle_on) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Present one request and hold it until the block takes it. Called just
    // after a rising edge; returns just after the accepting edge, with valid
    // still high so that a following request can go out back to back.
    task automatic send_request(
        input logic        dir,
        input logic [31:0] secs,
        input logic [7:0]  yr,
        input logic [3:0]  mo,
        input logic [4:0]  dy,
        input logic [4:0]  hr,
        input logic [5:0]  mi,
        input logic [5:0]  se
    );
        // insert a random gap before the request
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= dir;
        i_seconds_in <= secs;
        i_year_in    <= yr;
        i_month_in   <= mo;
        i_day_in     <= dy;
        i_hour_in    <= hr;
        i_minute_in  <= mi;
        i_second_in  <= se;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (dir == DIR_TO_CAL) n_to_cal++;
        else n_to_secs++;
    endtask

    initial begin
        logic        dir;
        logic [31:0] secs;
        logic [7:0]  yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
        logic [4:0]  hr;
        logic [5:0]  mi;
        logic [5:0]  se;

        // hold reset from the start, then release it once and for all
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: seconds to calendar at the epoch, the top of the range,
        // around leap days and the FAT year boundary.
        send_request(DIR_TO_CAL, 32'd0,          '0, 4'd1, 5'd1, '0, '0, '0);
        send_request(DIR_TO_CAL, 32'hFFFF_FFFF,  '1, '1,   '1,   '1, '1, '1);
        send_request(DIR_TO_CAL, 32'h7FFF_FFFF,  '0, 4'd1, 5'd1, '0, '0, '0);
        send_request(DIR_TO_CAL, 32'd951782400,  '0, 4'd1, 5'd1, '0, '0, '0);
        send_request(DIR_TO_CAL, 32'd315532800,  '0, 4'd1, 5'd1, '0, '0, '0);
        send_request(DIR_TO_CAL, 32'd315532799,  '0, 4'd1, 5'd1, '0, '0, '0);
        send_request(DIR_TO_CAL, 32'd4107455999, '0, 4'd1, 5'd1, '0, '0, '0);
        send_request(DIR_TO_CAL, 32'd4107542400, '0, 4'd1, 5'd1, '0, '0, '0);
        send_request(DIR_TO_CAL, 32'd68169599,   '0, 4'd1, 5'd1, '0, '0, '0);

        // Directed: calendar to seconds, in range and at the field extremes.
        send_request(DIR_TO_SECS, '0, 8'd0,   4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
        send_request(DIR_TO_SECS, '1, 8'd136, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15);
        send_request(DIR_TO_SECS, '0, 8'd136, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        send_request(DIR_TO_SECS, '0, 8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
        send_request(DIR_TO_SECS, '0, 8'd30,  4'd2,  5'd29, 5'd12, 6'd30, 6'd31);
        send_request(DIR_TO_SECS, '0, 8'd130, 4'd3,  5'd1,  5'd0,  6'd0,  6'd1);
        // month zero adds no months, months above twelve add the whole year
        send_request(DIR_TO_SECS, '0, 8'd40,  4'd0,  5'd10, 5'd1,  6'd2,  6'd3);
        send_request(DIR_TO_SECS, '0, 8'd40,  4'd13, 5'd10, 5'd1,  6'd2,  6'd3);
        // day zero steps back a day, wrapping below the epoch
        send_request(DIR_TO_SECS, '0, 8'd0,   4'd1,  5'd0,  5'd0,  6'd0,  6'd0);
        send_request(DIR_TO_SECS, '0, 8'd20,  4'd6,  5'd0,  5'd5,  6'd5,  6'd5);
        // either side of the FAT year window
        send_request(DIR_TO_SECS, '0, 8'd9,   4'd12, 5'd31, 5'd23, 6'd59, 6'd58);
        send_request(DIR_TO_SECS, '0, 8'd10,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
        send_request(DIR_TO_SECS, '0, 8'd137, 4'd7,  5'd4,  5'd8,  6'd9,  6'd10);
        send_request(DIR_TO_SECS, '0, 8'd138, 4'd7,  5'd4,  5'd8,  6'd9,  6'd11);
        send_request(DIR_TO_SECS, '0, 8'd200, 4'd9,  5'd17, 5'd24, 6'd60, 6'd61);

        // Random: mostly well-formed dates, some raw field noise.
        for (int n = 0; n < N_RANDOM; n++) begin
            // drop idling for one long stretch
            if (n == 200) idle_on <= 1'b0;
            if (n == 350) idle_on <= 1'b1;
            dir  = 1'($urandom_range(1));
            secs = $urandom;
            if ($urandom_range(99) < 70) begin
                yr = 8'($urandom_range(136));
                mo = 4'($urandom_range(12, 1));
                dy = 5'($urandom_range(31, 1));
                hr = 5'($urandom_range(23));
                mi = 6'($urandom_range(59));
                se = 6'($urandom_range(59));
            end else begin
                yr = 8'($urandom);
                mo = 4'($urandom);
                dy = 5'($urandom);
                hr = 5'($urandom);
                mi = 6'($urandom);
                se = 6'($urandom);
            end
            send_request(dir, secs, yr, mo, dy, hr, mi, se);
            // hold off once until every result so far has drained
            if (n == 450) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (outstanding != 0) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        // drain, then allow the block's worst latency for stray results
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d requests sent: %0d seconds to calendar, %0d calendar to seconds",
                 n_to_cal + n_to_secs, n_to_cal, n_to_secs);
        $display("%0d results compared, %0d mismatches", results, errors);
        if (errors == 0 && outstanding == 0) begin
            $display("tb_unix_time_calendar_converter_core: done, clean");
        end else begin
            $display("tb_unix_time_calendar_converter_core: done, errors");
        end
        $finish;
    end

    // Give up after a generous fixed time.
    initial begin
        #20_000_000;
        $display("timeout with %0d results still outstanding", outstanding);
        $display("tb_unix_time_calendar_converter_core: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/uttc_pkg.sv
hdl/uttc_dpath.sv
hdl/uttc_ctrl.sv
hdl/unix_time_calendar_converter_core.sv
hdl/uttc_checker.sv
tb/sv/uttc_checker.sv
tb/sv/tb_unix_time_calendar_converter_core.sv
